// ===== rtl/cte_pkg.sv =====
`default_nettype none
package cte_pkg;

  localparam int unsigned NUM_EDGES = 3;
  localparam int unsigned LANE_DEPTH = 6;

  typedef enum logic [1:0] {
    EDGE_AB = 2'd0,
    EDGE_BC = 2'd1,
    EDGE_AC = 2'd2
  } edge_e;

endpackage
`default_nettype wire

// ===== rtl/cte_lane.sv =====
`default_nettype none
module cte_lane #(
  parameter int unsigned W = 16
) (
  input  wire logic                clk_i,
  input  wire logic                en_i,
  input  wire logic signed [W-1:0] px_i,
  input  wire logic signed [W-1:0] py_i,
  input  wire logic signed [W-1:0] qx_i,
  input  wire logic signed [W-1:0] qy_i,
  input  wire logic signed [W-1:0] cx_i,
  input  wire logic signed [W-1:0] cy_i,
  input  wire logic        [W-2:0] r_i,
  output logic                     hit_o
);

  localparam int unsigned D1 = W + 1;
  localparam int unsigned P  = 2 * W + 2;
  localparam int unsigned E  = 2 * W + 4;
  localparam int unsigned L  = W + 1;
  localparam int unsigned M  = 2 * L;
  localparam int unsigned PW = 2 * M + 1;

  logic signed [D1-1:0] xx_q, xy_q, yx_q, yy_q, ux_q, uy_q;
  logic        [W-2:0]  r_q;

  logic signed [P-1:0]  p_xyx_q, p_xyy_q, p_yx2_q, p_yy2_q, p_xx2_q, p_xy2_q, p_ux2_q, p_uy2_q;
  logic        [2*W-3:0] r2_q;

  logic signed [E-1:0]  a_q, h_q, f0_q, f1_q;

  logic        [M-1:0]  mh_d, mc_d;
  logic signed [E-1:0]  ah_d;
  logic                 vtx_d, cross_d, pos_d;
  logic        [M-1:0]  hh_q, hl_q, ll_q, ahch_q, ahcl_q, alch_q, alcl_q;
  logic                 zr4_q, cross4_q, pos4_q;

  logic        [PW-1:0] h2_q, ac_q;
  logic                 zr5_q, cross5_q, pos5_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xx_q <= D1'(px_i) - D1'(cx_i);
      xy_q <= D1'(py_i) - D1'(cy_i);
      yx_q <= D1'(qx_i) - D1'(px_i);
      yy_q <= D1'(qy_i) - D1'(py_i);
      ux_q <= D1'(qx_i) - D1'(cx_i);
      uy_q <= D1'(qy_i) - D1'(cy_i);
      r_q  <= r_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_xyx_q <= P'(xx_q) * P'(yx_q);
      p_xyy_q <= P'(xy_q) * P'(yy_q);
      p_yx2_q <= P'(yx_q) * P'(yx_q);
      p_yy2_q <= P'(yy_q) * P'(yy_q);
      p_xx2_q <= P'(xx_q) * P'(xx_q);
      p_xy2_q <= P'(xy_q) * P'(xy_q);
      p_ux2_q <= P'(ux_q) * P'(ux_q);
      p_uy2_q <= P'(uy_q) * P'(uy_q);
      r2_q    <= (2*W-2)'(r_q) * (2*W-2)'(r_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q  <= E'(p_yx2_q) + E'(p_yy2_q);
      h_q  <= E'(p_xyx_q) + E'(p_xyy_q);
      f0_q <= E'(p_xx2_q) + E'(p_xy2_q) - E'(r2_q);
      f1_q <= E'(p_ux2_q) + E'(p_uy2_q) - E'(r2_q);
    end
  end

  always_comb begin
    mh_d    = h_q[E-1] ? M'(-h_q) : M'(h_q);
    mc_d    = (!f0_q[E-1] && f0_q != '0) ? M'(f0_q) : '0;
    ah_d    = a_q + h_q;
    vtx_d   = (h_q[E-1] || h_q == '0) && !ah_d[E-1];
    cross_d = ((f0_q[E-1] || f0_q == '0) && !f1_q[E-1])
           || (!f0_q[E-1] && (f1_q[E-1] || f1_q == '0));
    pos_d   = !f0_q[E-1] && f0_q != '0 && !f1_q[E-1] && f1_q != '0 && vtx_d;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hh_q     <= M'(mh_d[M-1:L]) * M'(mh_d[M-1:L]);
      hl_q     <= M'(mh_d[M-1:L]) * M'(mh_d[L-1:0]);
      ll_q     <= M'(mh_d[L-1:0]) * M'(mh_d[L-1:0]);
      ahch_q   <= M'(a_q[M-1:L]) * M'(mc_d[M-1:L]);
      ahcl_q   <= M'(a_q[M-1:L]) * M'(mc_d[L-1:0]);
      alch_q   <= M'(a_q[L-1:0]) * M'(mc_d[M-1:L]);
      alcl_q   <= M'(a_q[L-1:0]) * M'(mc_d[L-1:0]);
      zr4_q    <= (a_q == '0);
      cross4_q <= cross_d;
      pos4_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h2_q     <= (PW'(hh_q) << (2*L)) + (PW'(hl_q) << (L+1)) + PW'(ll_q);
      ac_q     <= (PW'(ahch_q) << (2*L)) + ((PW'(ahcl_q) + PW'(alch_q)) << L) + PW'(alcl_q);
      zr5_q    <= zr4_q;
      cross5_q <= cross4_q;
      pos5_q   <= pos4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_o <= !zr5_q && (cross5_q || (pos5_q && h2_q >= ac_q));
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cte_merge.sv =====
`default_nettype none
module cte_merge (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           en_i,
  input  wire logic                           valid_i,
  input  wire logic [cte_pkg::NUM_EDGES-1:0]  lane_hit_i,
  output logic                                valid_o,
  output logic                                hit_o
);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_o <= |lane_hit_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/circle_triangle_edge_collision_top.sv =====
`default_nettype none
// channel  signals                        accepted when
// request  valid_i, stall_o, fields _i    valid_i && !stall_o
// result   valid_o, stall_i, hit_o        valid_o && !stall_i
//
// One request per cycle while the result is not stalled; 6 lane stages, 1 merge stage.
// Edges AB, BC and AC each run in a lane of their own; the widest step is the split
// (W+1)x(W+1) multiply of the discriminant terms.
// Reset clears the valid chain only. A stalled result freezes the whole pipe.
module circle_triangle_edge_collision_top #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  output logic                               stall_o,
  input  wire logic signed [COORD_WIDTH-1:0] center_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] center_y_i,
  input  wire logic        [COORD_WIDTH-2:0] radius_i,
  input  wire logic signed [COORD_WIDTH-1:0] vert_a_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] vert_a_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] vert_b_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] vert_b_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] vert_c_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] vert_c_y_i,
  output logic                               valid_o,
  input  wire logic                          stall_i,
  output logic                               hit_o
);

  logic                                en;
  logic [cte_pkg::LANE_DEPTH-1:0]      valid_q;
  logic [cte_pkg::NUM_EDGES-1:0]       lane_hit;

  assign en      = !(valid_o && stall_i);
  assign stall_o = valid_o && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[cte_pkg::LANE_DEPTH-2:0], valid_i};
    end
  end

  cte_lane #(.W(COORD_WIDTH)) u_lane_ab (
    .clk_i, .en_i(en),
    .px_i(vert_a_x_i), .py_i(vert_a_y_i), .qx_i(vert_b_x_i), .qy_i(vert_b_y_i),
    .cx_i(center_x_i), .cy_i(center_y_i), .r_i(radius_i),
    .hit_o(lane_hit[cte_pkg::EDGE_AB])
  );

  cte_lane #(.W(COORD_WIDTH)) u_lane_bc (
    .clk_i, .en_i(en),
    .px_i(vert_b_x_i), .py_i(vert_b_y_i), .qx_i(vert_c_x_i), .qy_i(vert_c_y_i),
    .cx_i(center_x_i), .cy_i(center_y_i), .r_i(radius_i),
    .hit_o(lane_hit[cte_pkg::EDGE_BC])
  );

  cte_lane #(.W(COORD_WIDTH)) u_lane_ac (
    .clk_i, .en_i(en),
    .px_i(vert_a_x_i), .py_i(vert_a_y_i), .qx_i(vert_c_x_i), .qy_i(vert_c_y_i),
    .cx_i(center_x_i), .cy_i(center_y_i), .r_i(radius_i),
    .hit_o(lane_hit[cte_pkg::EDGE_AC])
  );

  cte_merge u_merge (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(valid_q[cte_pkg::LANE_DEPTH-1]),
    .lane_hit_i(lane_hit),
    .valid_o, .hit_o
  );

endmodule
`default_nettype wire

// ===== bench/circle_triangle_edge_collision_checker.sv =====
`timescale 1ns / 1ps
module circle_triangle_edge_collision_checker #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  input  wire logic                          stall_o,
  input  wire logic signed [COORD_WIDTH-1:0] center_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] center_y_i,
  input  wire logic        [COORD_WIDTH-2:0] radius_i,
  input  wire logic signed [COORD_WIDTH-1:0] vert_a_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] vert_a_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] vert_b_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] vert_b_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] vert_c_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] vert_c_y_i,
  input  wire logic                          valid_o,
  input  wire logic                          stall_i,
  input  wire logic                          hit_o,
  output int                                 errors_o,
  output int                                 pending_o
);

  typedef logic signed [159:0] exact_t;

  logic hit_expect_q[$];
  int   errors;

  // exact circle-boundary crossing test for the edge P->Q
  function automatic logic edge_crosses(longint px, longint py, longint qx, longint qy,
                                        longint cx, longint cy, longint r);
    exact_t xx, xy, yx, yy, a, h, c, d, k;
    xx = px - cx;
    xy = py - cy;
    yx = qx - px;
    yy = qy - py;
    if (yx == 0 && yy == 0) return 1'b0;
    a = yx * yx + yy * yy;
    h = xx * yx + xy * yy;
    c = xx * xx + xy * xy - exact_t'(r) * exact_t'(r);
    d = h * h - a * c;
    if (d < 0) return 1'b0;
    // smaller root: 0 <= -h - sqrt(d) <= a
    k = -h;
    if ((k >= 0 && k * k >= d) && ((k - a) <= 0 || d >= (k - a) * (k - a)))
      return 1'b1;
    // larger root: 0 <= -h + sqrt(d) <= a
    k = a + h;
    if ((h <= 0 || d >= h * h) && (k >= 0 && k * k >= d)) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic predict_hit();
    longint cx, cy, r, ax, ay, bx, by, qx, qy;
    cx = center_x_i;
    cy = center_y_i;
    r  = longint'(radius_i);
    ax = vert_a_x_i;
    ay = vert_a_y_i;
    bx = vert_b_x_i;
    by = vert_b_y_i;
    qx = vert_c_x_i;
    qy = vert_c_y_i;
    return edge_crosses(ax, ay, bx, by, cx, cy, r) ||
           edge_crosses(bx, by, qx, qy, cx, cy, r) ||
           edge_crosses(ax, ay, qx, qy, cx, cy, r);
  endfunction

  always @(posedge clk_i) begin
    logic want;
    if (rst_ni) begin
      if (valid_i && !stall_o) hit_expect_q.push_back(predict_hit());
      if (valid_o && !stall_i) begin
        if (hit_expect_q.size() == 0) begin
          errors = errors + 1;
          if (errors <= 10) $display("unexpected result hit=%0b at %0t", hit_o, $realtime);
        end else begin
          want = hit_expect_q.pop_front();
          if (hit_o !== want) begin
            errors = errors + 1;
            if (errors <= 10)
              $display("hit mismatch: expected %0b actual %0b at %0t", want, hit_o, $realtime);
          end
        end
      end
    end
    errors_o  <= errors;
    pending_o <= hit_expect_q.size();
  end

  initial begin
    errors    = 0;
    errors_o  = 0;
    pending_o = 0;
  end

endmodule

// ===== bench/circle_triangle_edge_collision_top_tb.sv =====
`timescale 1ns / 1ps
module circle_triangle_edge_collision_top_tb;

  localparam int unsigned W = 16;

  logic                clk_i;
  logic                rst_ni;
  logic                valid_i;
  logic                stall_o;
  logic signed [W-1:0] center_x_i, center_y_i;
  logic        [W-2:0] radius_i;
  logic signed [W-1:0] vert_a_x_i, vert_a_y_i, vert_b_x_i, vert_b_y_i;
  logic signed [W-1:0] vert_c_x_i, vert_c_y_i;
  logic                valid_o;
  logic                stall_i;
  logic                hit_o;
  int                  errors, pending;
  int                  idle_pct, stall_pct;

  circle_triangle_edge_collision_top #(.COORD_WIDTH(W)) dut (.*);

  circle_triangle_edge_collision_checker #(.COORD_WIDTH(W)) u_checker (
    .errors_o (errors),
    .pending_o(pending),
    .*
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  always @(posedge clk_i) stall_i <= ($urandom_range(99) < stall_pct);

  function automatic logic signed [W-1:0] clamp(int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return W'(v);
  endfunction

  // hold the request until accepted, then maybe idle
  task automatic send_request(int cx, int cy, int r, int ax, int ay, int bx, int by,
                              int qx, int qy);
    center_x_i <= W'(cx);
    center_y_i <= W'(cy);
    radius_i   <= (W-1)'(r);
    vert_a_x_i <= W'(ax);
    vert_a_y_i <= W'(ay);
    vert_b_x_i <= W'(bx);
    vert_b_y_i <= W'(by);
    vert_c_x_i <= W'(qx);
    vert_c_y_i <= W'(qy);
    valid_i    <= 1'b1;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic send_random();
    int cx, cy, r, span, v[6];
    int sel;
    sel = $urandom_range(99);
    if (sel < 30) begin
      send_request($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom);
    end else begin
      cx   = $signed(16'($urandom));
      cy   = $signed(16'($urandom));
      r    = (sel < 45) ? $urandom_range(0, 32767) : $urandom_range(0, 3000);
      span = 2 * r + 64;
      foreach (v[i]) v[i] = ((i % 2) ? cy : cx) + $urandom_range(0, 2 * span) - span;
      if ($urandom_range(9) == 0) begin
        v[2] = v[0];
        v[3] = v[1];
      end
      send_request(cx, cy, r, clamp(v[0]), clamp(v[1]), clamp(v[2]), clamp(v[3]),
                   clamp(v[4]), clamp(v[5]));
    end
  endtask

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_ni     = 1'b0;
    valid_i    = 1'b0;
    stall_i    = 1'b0;
    center_x_i = '0;
    center_y_i = '0;
    radius_i   = '0;
    vert_a_x_i = '0;
    vert_a_y_i = '0;
    vert_b_x_i = '0;
    vert_b_y_i = '0;
    vert_c_x_i = '0;
    vert_c_y_i = '0;
    idle_pct   = 0;
    stall_pct  = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_request(0, 0, 32767, -32768, -32768, 32767, -32768, 0, 32767);
    send_request(-32768, -32768, 32767, 32767, 32767, -32768, 32767, 32767, -32768);
    send_request(32767, 32767, 0, 32767, 32767, 0, 0, -32768, 0);
    send_request(-32768, 32767, 32767, -32768, 32767, 32767, -32768, -32768, -32768);
    // tangent to edge AB
    send_request(0, 160, 160, -320, 0, 320, 0, 0, -320);
    // circle wholly inside triangle
    send_request(0, 0, 16, -1600, -1600, 1600, -1600, 0, 1600);
    // triangle wholly inside circle
    send_request(0, 0, 8000, -16, -16, 16, -16, 0, 16);
    // zero-length edges only
    send_request(0, 0, 100, 50, 0, 50, 0, 50, 0);
    // one zero-length edge, others crossing
    send_request(0, 0, 100, -200, 0, -200, 0, 200, 0);
    // circle well clear
    send_request(10000, 10000, 50, -100, -100, 100, -100, 0, 100);
    // vertex on boundary
    send_request(0, 0, 100, 100, 0, 300, 0, 300, 300);
    // edge ending just inside
    send_request(0, 0, 100, 99, 0, 500, 0, 500, 500);
    send_request(0, 0, 1, 1, 0, 0, 1, -1, 0);
    send_request(-1, -1, 32767, 32767, 32767, 32767, -32768, -32768, 32767);
    send_request(100, 100, 50, 100, 0, 100, 200, 300, 100);

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = (phase == 1) ? 45 : (phase == 3) ? 20 : 0;
      stall_pct = (phase == 2) ? 45 : (phase == 3) ? 20 : 0;
      repeat (260) send_random();
    end
    valid_i <= 1'b0;
    @(posedge clk_i);

    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
